[design/btff_pkg.sv]
// Shared types, constants and sequencer codes of the boundary-tag heap allocator.
package btff_pkg;

	localparam int WORD_BYTES  = 4;
	localparam int HEAP_WORDS  = 4096;
	localparam int CHUNK_BYTES = 4096;
	localparam int DBL_BYTES   = 2 * WORD_BYTES;
	localparam int MIN_BLOCK   = 2 * DBL_BYTES;
	localparam int HEAP_BYTES  = HEAP_WORDS * WORD_BYTES;

	localparam int ADDR_W = $clog2(HEAP_BYTES);
	localparam int WIDX_W = $clog2(HEAP_WORDS);
	localparam int BRK_W  = ADDR_W + 1;
	localparam int ASZ_W  = 17;

	localparam logic [31:0] SIZE_MASK = ~32'd7;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2
	} op_t;

	typedef enum logic [5:0] {
		S_IDLE, S_DECODE,
		S_INIT0, S_INIT1, S_INIT2, S_INIT3,
		S_GROW_CHK, S_GROW_W0, S_GROW_W1, S_GROW_W2,
		S_M1R, S_M1C, S_M2R, S_M2C, S_M3R, S_M3C, S_M4R, S_M4C, S_M5R, S_M5C, S_MBR,
		S_MA_W0, S_MA_W1,
		S_MB_W0, S_MB_R, S_MB_C, S_MB_W1,
		S_MC_R, S_MC_C, S_MC_W0, S_MC_R2, S_MC_C2, S_MC_R3, S_MC_C3, S_MC_W1,
		S_RET_R, S_RET_C,
		S_FR_R, S_FR_C, S_FR_W0, S_FR_W1,
		S_FF_R, S_FF_C,
		S_CV_R, S_CV_C, S_CV_B, S_CV_S0, S_CV_S1, S_CV_S2, S_CV_S3, S_CV_N0, S_CV_N1,
		S_OK, S_FAIL, S_DONE
	} state_t;

	typedef struct packed {
		logic is_init;
		logic is_alloc;
		logic is_free;
		logic req_zero;
		logic brk_zero;
		logic grow_fail;
		logic ff_zero;
		logic ff_fit;
		logic ff_past;
		logic pa;
		logic na;
		logic split;
	} dp_stat_t;

endpackage

[design/boundary_tag_first_fit_allocator.sv]
// Top level of the boundary-tag first-fit heap allocator.
//
// Usage: raise start with operation (init, allocate, free), request_bytes and
// payload_address while busy is low; the transaction is taken at that edge and
// busy stays high until the result has been shown. The result (status,
// block_address) is marked by done, which is high for exactly one cycle; the
// receiver cannot stall it and must take it in that cycle. The next
// transaction may start in the cycle after done.
// Sequencing: every heap word read has an issue state and a capture state on
// the single-port heap RAM, and a write has a single state. Init writes the
// prologue and epilogue words and then grows the heap. The steps of a free
// depend on which neighbors merge; while no heap exists, a free succeeds
// without touching the heap. Allocate walks the block headers in a first-fit
// scan and then carves the block, growing the heap first when the scan finds
// no fit; a zero request or a missing heap fails without a scan. Transactions
// are taken one at a time, set by the sequencer walking the heap through the RAM port.
// Reset: the break and the sequencer clear at once; heap contents are undefined
// until init writes them, and allocate fails while no heap exists.
module boundary_tag_first_fit_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  operation,
	input  logic [15:0]                 request_bytes,
	input  logic [btff_pkg::ADDR_W-1:0] payload_address,
	output logic                        done,
	output logic                        status,
	output logic [btff_pkg::ADDR_W-1:0] block_address
);
	import btff_pkg::*;

	// sequencer code drives the datapath, flags come back
	state_t   cmd;
	dp_stat_t stat;

	btff_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	btff_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.operation       (operation),
		.request_bytes   (request_bytes),
		.payload_address (payload_address),
		.stat            (stat),
		.status          (status),
		.block_address   (block_address)
	);
endmodule

[design/btff_ram.sv]
// Generic single-port RAM with registered read.
module btff_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[design/btff_ctrl.sv]
// Sequencer of the allocator: walks init, first-fit, grow, merge, carve and free steps.
module btff_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  btff_pkg::dp_stat_t stat,
	output btff_pkg::state_t  cmd,
	output logic              busy,
	output logic              done
);
	import btff_pkg::*;

	state_t st_q, nxt, after_merge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= nxt;
		end
	end

	always_comb begin
		after_merge = stat.is_alloc ? S_CV_R : S_OK;
		nxt = st_q;
		cmd = st_q;
		busy = (st_q != S_IDLE);
		done = (st_q == S_DONE);
		case (st_q)
			S_IDLE: if (start) nxt = S_DECODE;
			S_DECODE: begin
				if (stat.is_init) nxt = S_INIT0;
				else if (stat.is_alloc)
					nxt = (stat.req_zero || stat.brk_zero) ? S_FAIL : S_FF_R;
				else if (stat.is_free) nxt = stat.brk_zero ? S_OK : S_FR_R;
				else nxt = S_FAIL;
			end
			S_INIT0: nxt = S_INIT1;
			S_INIT1: nxt = S_INIT2;
			S_INIT2: nxt = S_INIT3;
			S_INIT3: nxt = S_GROW_CHK;
			S_GROW_CHK: nxt = stat.grow_fail ? S_FAIL : S_GROW_W0;
			S_GROW_W0: nxt = S_GROW_W1;
			S_GROW_W1: nxt = S_GROW_W2;
			S_GROW_W2: nxt = S_M1R;
			S_M1R: nxt = S_M1C;
			S_M1C: nxt = S_M2R;
			S_M2R: nxt = S_M2C;
			S_M2C: nxt = S_M3R;
			S_M3R: nxt = S_M3C;
			S_M3C: nxt = S_M4R;
			S_M4R: nxt = S_M4C;
			S_M4C: nxt = S_M5R;
			S_M5R: nxt = S_M5C;
			S_M5C: nxt = S_MBR;
			S_MBR: begin
				if (stat.pa && stat.na) nxt = after_merge;
				else if (stat.pa) nxt = S_MA_W0;
				else if (stat.na) nxt = S_MB_W0;
				else nxt = S_MC_R;
			end
			S_MA_W0: nxt = S_MA_W1;
			S_MA_W1: nxt = after_merge;
			S_MB_W0: nxt = S_MB_R;
			S_MB_R: nxt = S_MB_C;
			S_MB_C: nxt = S_MB_W1;
			S_MB_W1: nxt = S_RET_R;
			S_MC_R: nxt = S_MC_C;
			S_MC_C: nxt = S_MC_W0;
			S_MC_W0: nxt = S_MC_R2;
			S_MC_R2: nxt = S_MC_C2;
			S_MC_C2: nxt = S_MC_R3;
			S_MC_R3: nxt = S_MC_C3;
			S_MC_C3: nxt = S_MC_W1;
			S_MC_W1: nxt = S_RET_R;
			S_RET_R: nxt = S_RET_C;
			S_RET_C: nxt = after_merge;
			S_FR_R: nxt = S_FR_C;
			S_FR_C: nxt = S_FR_W0;
			S_FR_W0: nxt = S_FR_W1;
			S_FR_W1: nxt = S_M1R;
			S_FF_R: nxt = S_FF_C;
			S_FF_C: begin
				if (stat.ff_zero) nxt = S_GROW_CHK;
				else if (stat.ff_fit) nxt = S_CV_R;
				else if (stat.ff_past) nxt = S_GROW_CHK;
				else nxt = S_FF_R;
			end
			S_CV_R: nxt = S_CV_C;
			S_CV_C: nxt = S_CV_B;
			S_CV_B: nxt = stat.split ? S_CV_S0 : S_CV_N0;
			S_CV_S0: nxt = S_CV_S1;
			S_CV_S1: nxt = S_CV_S2;
			S_CV_S2: nxt = S_CV_S3;
			S_CV_S3: nxt = S_OK;
			S_CV_N0: nxt = S_CV_N1;
			S_CV_N1: nxt = S_OK;
			S_OK: nxt = S_DONE;
			S_FAIL: nxt = S_DONE;
			S_DONE: nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end
endmodule

[design/btff_dp.sv]
// Datapath of the allocator: heap memory, break, walk registers and address arithmetic.
module btff_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  btff_pkg::state_t                cmd,
	input  logic [1:0]                      operation,
	input  logic [15:0]                     request_bytes,
	input  logic [btff_pkg::ADDR_W-1:0]     payload_address,
	output btff_pkg::dp_stat_t              stat,
	output logic                            status,
	output logic [btff_pkg::ADDR_W-1:0]     block_address
);
	import btff_pkg::*;

	logic [1:0]        op_q;
	logic [15:0]       req_q;
	logic [ADDR_W-1:0] pay_q;
	logic [BRK_W-1:0]  brk_q;
	logic [BRK_W-1:0]  bp_q;
	logic [ADDR_W-1:0] prev_q, next_q;
	logic [31:0]       ph_q, nh_q, s_q, acc_q, cs_q;
	logic              pa_q, na_q;
	logic [ASZ_W-1:0]  gs_q;
	logic              status_q;
	logic [ADDR_W-1:0] addr_q;

	logic [31:0]       ram_q, ram_d, sz;
	logic [ADDR_W-1:0] baddr, bp14, szl;
	logic              ram_we;
	logic [ASZ_W-1:0]  asize, gbytes, gwords, gs;
	logic [32:0]       nx;

	assign bp14 = bp_q[ADDR_W-1:0];
	assign sz   = ram_q & SIZE_MASK;
	assign szl  = sz[ADDR_W-1:0];
	assign nx   = {1'b0, sz} + 33'(bp_q);

	// round the request up to an aligned block with room for header and footer
	always_comb begin
		if (req_q <= 16'(DBL_BYTES))
			asize = ASZ_W'(MIN_BLOCK);
		else
			asize = (ASZ_W'(req_q) + ASZ_W'(DBL_BYTES + DBL_BYTES - 1)) & ~ASZ_W'(DBL_BYTES - 1);
		gbytes = (op_q == OP_ALLOC && asize > ASZ_W'(CHUNK_BYTES)) ? asize : ASZ_W'(CHUNK_BYTES);
		gwords = gbytes >> 2;
		if (gwords[0]) gwords = gwords + ASZ_W'(1);
		gs = gwords << 2;
	end

	always_comb begin
		stat.is_init   = (op_q == OP_INIT);
		stat.is_alloc  = (op_q == OP_ALLOC);
		stat.is_free   = (op_q == OP_FREE);
		stat.req_zero  = (req_q == 16'd0);
		stat.brk_zero  = (brk_q == '0);
		stat.grow_fail = (18'(brk_q) + 18'(gs)) > 18'(HEAP_BYTES);
		stat.ff_zero   = (sz == 32'd0);
		stat.ff_fit    = !ram_q[0] && (32'(asize) <= sz);
		stat.ff_past   = nx > 33'(brk_q);
		stat.pa        = pa_q;
		stat.na        = na_q;
		stat.split     = (cs_q - 32'(asize)) >= 32'(MIN_BLOCK);
	end

	// memory address and write data for each step
	always_comb begin
		baddr = '0;
		ram_d = '0;
		ram_we = 1'b0;
		case (cmd)
			S_INIT0: begin baddr = '0; ram_we = 1'b1; end
			S_INIT1: begin
				baddr = ADDR_W'(WORD_BYTES); ram_d = 32'(DBL_BYTES) | 32'd1; ram_we = 1'b1;
			end
			S_INIT2: begin
				baddr = ADDR_W'(2 * WORD_BYTES); ram_d = 32'(DBL_BYTES) | 32'd1; ram_we = 1'b1;
			end
			S_INIT3: begin baddr = ADDR_W'(3 * WORD_BYTES); ram_d = 32'd1; ram_we = 1'b1; end
			S_GROW_W0: begin
				baddr = bp14 - ADDR_W'(WORD_BYTES); ram_d = 32'(gs_q); ram_we = 1'b1;
			end
			S_GROW_W1: begin
				baddr = bp14 + gs_q[ADDR_W-1:0] - ADDR_W'(DBL_BYTES);
				ram_d = 32'(gs_q); ram_we = 1'b1;
			end
			S_GROW_W2: begin
				baddr = bp14 + gs_q[ADDR_W-1:0] - ADDR_W'(WORD_BYTES);
				ram_d = 32'd1; ram_we = 1'b1;
			end
			S_M1R, S_MB_R, S_RET_R: baddr = bp14 - ADDR_W'(DBL_BYTES);
			S_M2R: baddr = prev_q - ADDR_W'(WORD_BYTES);
			S_M3R: baddr = prev_q + ph_q[ADDR_W-1:0] - ADDR_W'(DBL_BYTES);
			S_M4R, S_MC_R2, S_FF_R, S_CV_R: baddr = bp14 - ADDR_W'(WORD_BYTES);
			S_M5R, S_MC_R3: baddr = next_q - ADDR_W'(WORD_BYTES);
			S_MA_W0: begin baddr = bp14 - ADDR_W'(WORD_BYTES); ram_d = acc_q; ram_we = 1'b1; end
			S_MA_W1: begin
				baddr = bp14 + acc_q[ADDR_W-1:0] - ADDR_W'(DBL_BYTES); ram_d = acc_q; ram_we = 1'b1;
			end
			S_MB_W0: begin
				baddr = bp14 + s_q[ADDR_W-1:0] - ADDR_W'(DBL_BYTES); ram_d = acc_q; ram_we = 1'b1;
			end
			S_MB_W1, S_MC_W0: begin
				baddr = prev_q - ADDR_W'(WORD_BYTES); ram_d = acc_q; ram_we = 1'b1;
			end
			S_MC_R: baddr = next_q + nh_q[ADDR_W-1:0] - ADDR_W'(DBL_BYTES);
			S_MC_W1: begin
				baddr = next_q + nh_q[ADDR_W-1:0] - ADDR_W'(DBL_BYTES);
				ram_d = acc_q; ram_we = 1'b1;
			end
			S_FR_R: baddr = pay_q - ADDR_W'(WORD_BYTES);
			S_FR_W0: begin
				baddr = pay_q - ADDR_W'(WORD_BYTES); ram_d = acc_q; ram_we = 1'b1;
			end
			S_FR_W1: begin
				baddr = pay_q + acc_q[ADDR_W-1:0] - ADDR_W'(DBL_BYTES); ram_d = acc_q; ram_we = 1'b1;
			end
			S_CV_S0: begin
				baddr = bp14 - ADDR_W'(WORD_BYTES); ram_d = 32'(asize) | 32'd1; ram_we = 1'b1;
			end
			S_CV_S1: begin
				baddr = bp14 + asize[ADDR_W-1:0] - ADDR_W'(DBL_BYTES);
				ram_d = 32'(asize) | 32'd1; ram_we = 1'b1;
			end
			S_CV_S2: begin
				baddr = bp14 + asize[ADDR_W-1:0] - ADDR_W'(WORD_BYTES);
				ram_d = cs_q - 32'(asize); ram_we = 1'b1;
			end
			// remainder footer: split point plus remainder lands at the old footer
			S_CV_S3: begin
				baddr = bp14 + cs_q[ADDR_W-1:0] - ADDR_W'(DBL_BYTES);
				ram_d = cs_q - 32'(asize); ram_we = 1'b1;
			end
			S_CV_N0: begin
				baddr = bp14 - ADDR_W'(WORD_BYTES); ram_d = cs_q | 32'd1; ram_we = 1'b1;
			end
			S_CV_N1: begin
				baddr = bp14 + cs_q[ADDR_W-1:0] - ADDR_W'(DBL_BYTES);
				ram_d = cs_q | 32'd1; ram_we = 1'b1;
			end
			default: begin
				baddr = '0;
			end
		endcase
	end

	btff_ram #(.WIDTH(32), .DEPTH(HEAP_WORDS)) u_heap (
		.clk   (clk),
		.we    (ram_we),
		.addr  (baddr[ADDR_W-1 -: WIDX_W]),
		.wdata (ram_d),
		.rdata (ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brk_q <= '0;
		end else begin
			case (cmd)
				S_INIT0: brk_q <= BRK_W'(4 * WORD_BYTES);
				S_GROW_CHK: if (!stat.grow_fail) brk_q <= brk_q + gs[BRK_W-1:0];
				default: brk_q <= brk_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			S_IDLE: begin
				op_q  <= operation;
				req_q <= request_bytes;
				pay_q <= payload_address;
			end
			S_DECODE: bp_q <= (op_q == OP_FREE) ? {1'b0, pay_q} : BRK_W'(DBL_BYTES);
			S_GROW_CHK: begin
				bp_q <= brk_q;
				gs_q <= gs;
			end
			S_M1C, S_MB_C: prev_q <= bp14 - szl;
			S_M2C: ph_q <= sz;
			S_M3C: pa_q <= ram_q[0];
			S_M4C: begin
				s_q    <= sz;
				next_q <= bp14 + szl;
			end
			S_M5C: begin
				na_q <= ram_q[0];
				nh_q <= sz;
			end
			S_MBR: acc_q <= pa_q ? s_q + nh_q : s_q + ph_q;
			S_MC_C: acc_q <= acc_q + sz;
			S_MC_C2: next_q <= bp14 + szl;
			S_MC_C3: nh_q <= sz;
			S_RET_C: bp_q <= {1'b0, bp14 - szl};
			S_FR_C: acc_q <= sz;
			S_FF_C: if (!stat.ff_zero && !stat.ff_fit) bp_q <= nx[BRK_W-1:0];
			S_CV_C: cs_q <= sz;
			S_OK: begin
				status_q <= 1'b0;
				addr_q   <= (op_q == OP_ALLOC) ? bp14 : '0;
			end
			S_FAIL: begin
				status_q <= 1'b1;
				addr_q   <= '0;
			end
			default: op_q <= op_q;
		endcase
	end

	assign status        = status_q;
	assign block_address = addr_q;
endmodule

[design/btff_chk.sv]
// Port-level checks of the allocator and their bind to the top level.
module btff_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic                        status,
	input logic [btff_pkg::ADDR_W-1:0] block_address
);
	a_take: assert property (@(posedge clk) disable iff (!arst_n) start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result shown while idle");
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done longer than one cycle");
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> block_address == '0)
		else $error("failed transaction with nonzero address");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && $past(busy) |-> $past(done))
		else $error("busy dropped without a result");
endmodule

bind boundary_tag_first_fit_allocator btff_chk u_chk (.*);
